// ===== hw/rtl/text_console_tag_parser_cursor_assert.svh =====
// Assertion macros for the checker file of the text console block.
`ifndef TEXT_CONSOLE_TAG_PARSER_CURSOR_ASSERT_SVH
`define TEXT_CONSOLE_TAG_PARSER_CURSOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TCTP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tctp assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TCTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tctp assertion failed");

`endif

// ===== hw/rtl/tctp_pkg.sv =====
// Shared types, constants and helpers for the text console tag parser.
`timescale 1ns / 1ps
package tctp_pkg;

  localparam int unsigned POS_W   = 13;
  localparam int unsigned FORE_W  = 24;
  localparam int unsigned BACK_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TAG_DIGITS = 6;
  localparam int unsigned TAG_LEN = TAG_DIGITS + 3;
  localparam int unsigned CNT_W   = 4;

  localparam logic [POS_W:0]  GLYPH_WIDTH  = 14'd8;
  localparam logic [POS_W:0]  GLYPH_HEIGHT = 14'd16;
  localparam logic [POS_W:0]  POS_MAX      = 14'd8191;
  localparam logic [CNT_W-1:0] TAG_FULL    = CNT_W'(TAG_DIGITS + 2);

  localparam logic [FORE_W-1:0] FORE_RESET   = 24'hFFFFFF;
  localparam logic [POS_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [POS_W-1:0]  HEIGHT_RESET = 13'd480;
  localparam logic [BACK_W-1:0] BACK_RESET   = 32'd0;

  localparam logic [BYTE_W-1:0] CH_TERM    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_HASH    = 8'h23;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_BACKGROUND    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;       // append the input item to the byte buffer
    logic step;       // parse the byte at the pending count
    logic force_brk;  // break the held tag (terminator flush)
    logic finish;     // release the held draw as last of run
  } cmd_t;

  typedef struct packed {
    logic in_term;
    logic queue_empty;
    logic pend_zero;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [FORE_W-1:0] fore;
    logic [BACK_W-1:0] back;
  } draw_t;

  function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    return v;
  endfunction

  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + b;
    return (s > POS_MAX) ? POS_MAX[POS_W-1:0] : s[POS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/tctp_ctrl.sv =====
// Controller state machine: sequences load, parse steps, flush and finish.
`timescale 1ns / 1ps
module tctp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tctp_pkg::status_t  stat,
  output tctp_pkg::cmd_t     cmd
);

  tctp_pkg::state_t state, state_next;
  logic term, term_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tctp_pkg::ST_IDLE;
      term  <= 1'b0;
    end else begin
      state <= state_next;
      term  <= term_next;
    end
  end

  always_comb begin
    state_next = state;
    term_next  = term;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      tctp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          term_next  = stat.in_term;
          state_next = tctp_pkg::ST_RUN;
        end
      end
      tctp_pkg::ST_RUN: begin
        // every action may produce a draw, so wait for room downstream
        if (stat.out_free) begin
          if (!stat.queue_empty) begin
            cmd.step = 1'b1;
          end else if (term && !stat.pend_zero) begin
            cmd.force_brk = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            state_next = tctp_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = tctp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tctp_datapath.sv =====
// Datapath: byte buffer, tag decode, cursor, color and output register.
`timescale 1ns / 1ps
module tctp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tctp_pkg::cmd_t                      cmd,
  output tctp_pkg::status_t                   stat,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic [tctp_pkg::BYTE_W-1:0]         text_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tctp_pkg::BYTE_W-1:0]         glyph_code,
  output logic [tctp_pkg::POS_W-1:0]          pos_x,
  output logic [tctp_pkg::POS_W-1:0]          pos_y,
  output logic [tctp_pkg::FORE_W-1:0]         fore_color,
  output logic [tctp_pkg::BACK_W-1:0]         back_color,
  output logic                                last_of_run
);

  logic [tctp_pkg::BYTE_W-1:0] buf_q [tctp_pkg::TAG_LEN];
  logic [tctp_pkg::CNT_W-1:0]  pend_cnt;
  logic [tctp_pkg::CNT_W-1:0]  buf_len;
  logic [tctp_pkg::FORE_W-1:0] cur_fore;
  logic [tctp_pkg::POS_W-1:0]  cur_col;
  logic [tctp_pkg::POS_W-1:0]  cur_row;
  logic [tctp_pkg::POS_W-1:0]  screen_width;
  logic [tctp_pkg::POS_W-1:0]  screen_height;
  logic [tctp_pkg::BACK_W-1:0] background_color;
  tctp_pkg::draw_t             prev;
  logic                        have_prev;

  logic [tctp_pkg::BYTE_W-1:0] cur_byte;
  logic [tctp_pkg::BYTE_W-1:0] head;
  logic                        act_hold;
  logic                        act_done;
  logic                        act_put;
  logic                        is_nl;
  logic [tctp_pkg::POS_W-1:0]  row_w;
  logic [tctp_pkg::POS_W-1:0]  col_adv;
  logic                        line_wrap;
  logic [tctp_pkg::POS_W-1:0]  col_next;
  logic [tctp_pkg::POS_W-1:0]  row_next;
  logic [tctp_pkg::FORE_W-1:0] tag_color;
  logic                        push;
  logic                        out_free;

  assign cur_byte = buf_q[pend_cnt];
  assign head     = buf_q[0];
  assign is_nl    = (head == tctp_pkg::CH_NEWLINE);
  assign out_free = !out_valid || !out_stall;

  assign stat.in_term     = (text_byte == tctp_pkg::CH_TERM);
  assign stat.queue_empty = (pend_cnt == buf_len);
  assign stat.pend_zero   = (pend_cnt == '0);
  assign stat.out_free    = out_free;

  // Decode what the byte at the pending count does to the held tag
  always_comb begin
    act_hold = 1'b0;
    act_done = 1'b0;
    if (pend_cnt == 4'd0) begin
      act_hold = (cur_byte == tctp_pkg::CH_LBRACE);
    end else if (pend_cnt == 4'd1) begin
      act_hold = (cur_byte == tctp_pkg::CH_HASH);
    end else if (pend_cnt < tctp_pkg::TAG_FULL) begin
      act_hold = (cur_byte != tctp_pkg::CH_RBRACE);
    end else begin
      act_done = (cur_byte == tctp_pkg::CH_RBRACE);
    end
    act_hold = act_hold && cmd.step;
    act_done = act_done && cmd.step;
  end

  // Drawing or breaking both consume the head byte as a character
  assign act_put = cmd.force_brk || (cmd.step && !act_hold && !act_done);

  always_comb begin
    logic [tctp_pkg::POS_W:0] row_end;
    logic [tctp_pkg::POS_W:0] col_end;
    row_end   = {1'b0, cur_row} + tctp_pkg::GLYPH_HEIGHT;
    row_w     = (row_end > {1'b0, screen_height}) ? '0 : cur_row;
    col_adv   = tctp_pkg::sat_add(cur_col, tctp_pkg::GLYPH_WIDTH);
    col_end   = {1'b0, col_adv} + tctp_pkg::GLYPH_WIDTH;
    line_wrap = (col_end > {1'b0, screen_width});
    if (is_nl) begin
      col_next = '0;
      row_next = tctp_pkg::sat_add(cur_row, tctp_pkg::GLYPH_HEIGHT);
    end else if (line_wrap) begin
      col_next = '0;
      row_next = tctp_pkg::sat_add(row_w, tctp_pkg::GLYPH_HEIGHT);
    end else begin
      col_next = col_adv;
      row_next = row_w;
    end
  end

  always_comb begin
    tag_color = '0;
    for (int i = 0; i < int'(tctp_pkg::TAG_DIGITS); i++) begin
      tag_color = {tag_color[tctp_pkg::FORE_W-5:0], tctp_pkg::hex_value(buf_q[2 + i])};
    end
  end

  assign push = have_prev && ((act_put && !is_nl) || cmd.finish);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= tctp_pkg::WIDTH_RESET;
      screen_height    <= tctp_pkg::HEIGHT_RESET;
      background_color <= tctp_pkg::BACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tctp_pkg::CFG_SCREEN_WIDTH:  screen_width     <= cfg_data[tctp_pkg::POS_W-1:0];
        tctp_pkg::CFG_SCREEN_HEIGHT: screen_height    <= cfg_data[tctp_pkg::POS_W-1:0];
        tctp_pkg::CFG_BACKGROUND:    background_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte buffer: held tag bytes first, bytes still to parse after them
  always_ff @(posedge clk) begin
    if (cmd.load && !stat.in_term) begin
      buf_q[buf_len] <= text_byte;
    end else if (act_put) begin
      for (int i = 0; i < int'(tctp_pkg::TAG_LEN) - 1; i++) begin
        buf_q[i] <= buf_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt  <= '0;
      buf_len   <= '0;
      cur_fore  <= tctp_pkg::FORE_RESET;
      cur_col   <= '0;
      cur_row   <= '0;
      have_prev <= 1'b0;
    end else begin
      if (cmd.load && !stat.in_term) begin
        buf_len <= buf_len + 4'd1;
      end else if (act_put) begin
        buf_len  <= buf_len - 4'd1;
        pend_cnt <= '0;
      end else if (act_hold) begin
        pend_cnt <= pend_cnt + 4'd1;
      end else if (act_done) begin
        cur_fore <= tag_color;
        pend_cnt <= '0;
        buf_len  <= '0;
      end
      if (act_put) begin
        cur_col <= col_next;
        cur_row <= row_next;
      end
      if (act_put && !is_nl) begin
        have_prev <= 1'b1;
      end else if (cmd.finish) begin
        have_prev <= 1'b0;
      end
    end
  end

  // Hold one draw back until we know whether it closes the run
  always_ff @(posedge clk) begin
    if (act_put && !is_nl) begin
      prev.code <= head;
      prev.x    <= cur_col;
      prev.y    <= row_w;
      prev.fore <= cur_fore;
      prev.back <= background_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      glyph_code  <= prev.code;
      pos_x       <= prev.x;
      pos_y       <= prev.y;
      fore_color  <= prev.fore;
      back_color  <= prev.back;
      last_of_run <= cmd.finish;
    end
  end

endmodule

// ===== hw/rtl/text_console_tag_parser_cursor.sv =====
// Channel   | Handshake            | Payload
// in        | in_valid / in_stall  | text_byte
// out       | out_valid / out_stall| glyph_code pos_x pos_y fore_color back_color last_of_run
// cfg       | cfg_valid / cfg_ready| cfg_index cfg_data
//
// One item at a time: the byte is loaded, then parsed step by step (hold a tag
// byte, draw or break) while the output has room, then the run is closed.
// A byte that breaks a color tag replays the held tag bytes as characters.
// Each draw is held back until the next one or the run's close, so the last draw can be marked.
// out_stall on a valid output holds the controller in place; rst is synchronous, active high.
`timescale 1ns / 1ps
module text_console_tag_parser_cursor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tctp_pkg::BYTE_W-1:0]  text_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tctp_pkg::BYTE_W-1:0]  glyph_code,
  output logic [tctp_pkg::POS_W-1:0]   pos_x,
  output logic [tctp_pkg::POS_W-1:0]   pos_y,
  output logic [tctp_pkg::FORE_W-1:0]  fore_color,
  output logic [tctp_pkg::BACK_W-1:0]  back_color,
  output logic                         last_of_run,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);

  tctp_pkg::cmd_t    cmd;
  tctp_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  tctp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tctp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .text_byte   (text_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .glyph_code  (glyph_code),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .fore_color  (fore_color),
    .back_color  (back_color),
    .last_of_run (last_of_run)
  );

endmodule

// ===== hw/rtl/tctp_checker.sv =====
// Port-level checker for the text console block, bound to the top level.
`timescale 1ns / 1ps
`include "text_console_tag_parser_cursor_assert.svh"
module tctp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tctp_pkg::BYTE_W-1:0]  glyph_code,
  input logic [tctp_pkg::POS_W-1:0]   pos_x,
  input logic [tctp_pkg::POS_W-1:0]   pos_y,
  input logic [tctp_pkg::FORE_W-1:0]  fore_color,
  input logic [tctp_pkg::BACK_W-1:0]  back_color,
  input logic                         last_of_run
);

  // a stalled item keeps its payload
  `TCTP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(glyph_code) && $stable(pos_x) && $stable(pos_y) && $stable(fore_color) && $stable(back_color) && $stable(last_of_run))

  // an accepted byte keeps the block busy in the cycle after it
  `TCTP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // while more draws of the run are due, no new byte is taken
  `TCTP_ASSERT_NOW(a_run_open, out_valid && !last_of_run, in_stall)

endmodule

bind text_console_tag_parser_cursor tctp_checker u_tctp_checker (.*);
